/* hdl/dobd_pkg.sv */
`timescale 1ns / 1ps

package dobd_pkg;

  localparam int ACC_W  = 26;
  localparam int YMAG_W = 18;

  localparam logic [8:0]  CYC_YEARS = 9'd400;
  localparam logic [17:0] CYC_DAYS  = 18'd146097;
  localparam logic [8:0]  YEAR_DAYS = 9'd365;
  localparam logic [8:0]  LAST_YEAR = 9'd399;

  typedef struct packed {
    logic load;
    logic en;
    logic inv_acc;
    logic inv_k;
  } acc_ctl_t;

  // position in the 400-year cycle, 0 being the multiple of 400
  function automatic logic leap_in_cycle(input logic [8:0] a);
    return (a[1:0] == 2'b00) && (a != 9'd100) && (a != 9'd200) && (a != 9'd300);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
    logic [3:0] mc;
    logic [4:0] len;
    mc = m;
    if (m == 4'd0) begin
      mc = 4'd1;
    end else if (m > 4'd12) begin
      mc = 4'd12;
    end
    unique case (mc)
      4'd2: begin
        len = lp ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        len = 5'd30;
      end
      default: begin
        len = 5'd31;
      end
    endcase
    return len;
  endfunction

endpackage

/* hdl/dobd_accum.sv */
`timescale 1ns / 1ps

module dobd_accum (
  input  logic                            clk,
  input  dobd_pkg::acc_ctl_t              ctl,
  input  logic [dobd_pkg::ACC_W-1:0]      k,
  output logic [dobd_pkg::ACC_W-1:0]      acc,
  output logic [dobd_pkg::ACC_W-1:0]      sum
);

  logic [dobd_pkg::ACC_W-1:0] acc_r;
  logic [dobd_pkg::ACC_W-1:0] acc_nxt;
  logic [dobd_pkg::ACC_W-1:0] opa;
  logic [dobd_pkg::ACC_W-1:0] opb;
  logic [1:0]                 cin;

  // sum = (+/-acc) + (+/-k)
  always_comb begin
    opa = ctl.inv_acc ? ~acc_r : acc_r;
    opb = ctl.inv_k ? ~k : k;
    cin = {1'b0, ctl.inv_acc} + {1'b0, ctl.inv_k};
    sum = opa + opb + dobd_pkg::ACC_W'(cin);
    if (ctl.load) begin
      acc_nxt = k;
    end else if (ctl.en) begin
      acc_nxt = sum;
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

/* hdl/date_offset_by_days.sv */
`timescale 1ns / 1ps

// Channel   Ports                                  Handshake
// input     in_date_year .. in_offset_days         beat taken when start && !busy
// result    out_start_day_number .. out_range_error one beat per input, out_valid for one cycle
//
// The shared accumulator walks whole 400-year cycles, then single years, then months, first
// to build the day number and again to take it apart. busy stays high during the walk; the
// result beat is strobed in the first cycle with busy low, or in the cycle right after the
// accepting edge for an invalid year.
// Synchronous active-low reset returns the sequencer to idle and drops out_valid.
// The receiver cannot stall: every result beat is taken in its strobe cycle.

module date_offset_by_days #(
  parameter int MAX_YEAR = 9999
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [14:0] in_date_year,
  input  logic        [3:0]  in_date_month,
  input  logic        [4:0]  in_date_day,
  input  logic signed [23:0] in_offset_days,
  output logic               out_valid,
  output logic signed [22:0] out_start_day_number,
  output logic signed [24:0] out_end_day_number,
  output logic signed [14:0] out_end_year,
  output logic        [3:0]  out_end_month,
  output logic        [4:0]  out_end_day,
  output logic               out_range_error
);

  localparam int          AW         = dobd_pkg::ACC_W;
  localparam int          YW         = dobd_pkg::YMAG_W;
  localparam logic [31:0] MaxYear32  = 32'(MAX_YEAR);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TD_CYC = 4'd1;
  localparam logic [3:0] S_TD_YR  = 4'd2;
  localparam logic [3:0] S_TD_MON = 4'd3;
  localparam logic [3:0] S_TD_DAY = 4'd4;
  localparam logic [3:0] S_TD_OFF = 4'd5;
  localparam logic [3:0] S_FD_ABS = 4'd6;
  localparam logic [3:0] S_FD_CYC = 4'd7;
  localparam logic [3:0] S_FD_YR  = 4'd8;
  localparam logic [3:0] S_FD_MON = 4'd9;
  localparam logic [3:0] S_FD_DAY = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic          neg_r, neg_nxt;
  logic [14:0]   rem_r, rem_nxt;
  logic [8:0]    k_r, k_nxt;
  logic [3:0]    mon_r, mon_nxt;
  logic [3:0]    mon_in_r, mon_in_nxt;
  logic [4:0]    day_in_r, day_in_nxt;
  logic [23:0]   off_r, off_nxt;
  logic [22:0]   s_r, s_nxt;
  logic [24:0]   e_r, e_nxt;
  logic          epos_r, epos_nxt;
  logic [YW-1:0] ymag_r, ymag_nxt;
  logic [8:0]    j_r, j_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [22:0]   out_start_r, out_start_nxt;
  logic [24:0]   out_end_r, out_end_nxt;
  logic [14:0]   out_year_r, out_year_nxt;
  logic [3:0]    out_mon_r, out_mon_nxt;
  logic [4:0]    out_day_r, out_day_nxt;
  logic          out_err_r, out_err_nxt;

  dobd_pkg::acc_ctl_t ctl;
  logic [AW-1:0]      k_op;
  logic [AW-1:0]      acc;
  logic [AW-1:0]      sum;

  logic [14:0] yabs;
  logic        y_bad;
  logic        accept;
  logic        sum_pos;
  logic        acc_pos;
  logic [8:0]  ypos_in;
  logic        lp_in;
  logic [8:0]  ypos_e;
  logic        lp_e;
  logic [4:0]  mlen_in;
  logic [4:0]  mlen_cur;
  logic [4:0]  mlen_e;

  dobd_accum u_accum (
    .clk (clk),
    .ctl (ctl),
    .k   (k_op),
    .acc (acc),
    .sum (sum)
  );

  always_comb begin
    yabs    = in_date_year[14] ? (15'd0 - unsigned'(in_date_year)) : unsigned'(in_date_year);
    y_bad   = (in_date_year == 15'sd0) || ({17'd0, yabs} > MaxYear32);
    accept  = start && !busy;
    sum_pos = !sum[AW-1] && (sum != '0);
    acc_pos = !acc[AW-1] && (acc != '0);

    ypos_in = neg_r ? rem_r[8:0] : ((rem_r[8:0] == dobd_pkg::LAST_YEAR) ? 9'd0
                                                                          : rem_r[8:0] + 9'd1);
    lp_in   = dobd_pkg::leap_in_cycle(ypos_in);
    ypos_e  = epos_r ? ((j_r == dobd_pkg::CYC_YEARS) ? 9'd0 : j_r) : (j_r - 9'd1);
    lp_e    = dobd_pkg::leap_in_cycle(ypos_e);
    mlen_in  = dobd_pkg::month_len(mon_in_r, lp_in);
    mlen_cur = dobd_pkg::month_len(mon_r, lp_in);
    mlen_e   = dobd_pkg::month_len(mon_r, lp_e);
  end

  always_comb begin
    state_nxt  = state_r;
    neg_nxt    = neg_r;
    rem_nxt    = rem_r;
    k_nxt      = k_r;
    mon_nxt    = mon_r;
    mon_in_nxt = mon_in_r;
    day_in_nxt = day_in_r;
    off_nxt    = off_r;
    s_nxt      = s_r;
    e_nxt      = e_r;
    epos_nxt   = epos_r;
    ymag_nxt   = ymag_r;
    j_nxt      = j_r;

    out_valid_nxt = 1'b0;
    out_start_nxt = out_start_r;
    out_end_nxt   = out_end_r;
    out_year_nxt  = out_year_r;
    out_mon_nxt   = out_mon_r;
    out_day_nxt   = out_day_r;
    out_err_nxt   = out_err_r;

    ctl  = '0;
    k_op = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (y_bad) begin
            out_valid_nxt = 1'b1;
            out_start_nxt = '0;
            out_end_nxt   = '0;
            out_year_nxt  = '0;
            out_mon_nxt   = '0;
            out_day_nxt   = '0;
            out_err_nxt   = 1'b1;
          end else begin
            neg_nxt    = in_date_year[14];
            rem_nxt    = yabs - 15'd1;
            day_in_nxt = in_date_day;
            off_nxt    = in_offset_days;
            if (in_date_month == 4'd0) begin
              mon_in_nxt = 4'd1;
            end else if (in_date_month > 4'd12) begin
              mon_in_nxt = 4'd12;
            end else begin
              mon_in_nxt = in_date_month;
            end
            ctl.load  = 1'b1;
            state_nxt = S_TD_CYC;
          end
        end
      end
      S_TD_CYC: begin
        if (rem_r >= {6'd0, dobd_pkg::CYC_YEARS}) begin
          k_op    = AW'(dobd_pkg::CYC_DAYS);
          ctl.en  = 1'b1;
          rem_nxt = rem_r - {6'd0, dobd_pkg::CYC_YEARS};
        end else begin
          k_nxt     = '0;
          state_nxt = S_TD_YR;
        end
      end
      S_TD_YR: begin
        if ({6'd0, k_r} < rem_r) begin
          k_op   = AW'(dobd_pkg::YEAR_DAYS) +
                   AW'(dobd_pkg::leap_in_cycle(neg_r ? k_r : k_r + 9'd1));
          ctl.en = 1'b1;
          k_nxt  = k_r + 9'd1;
        end else begin
          mon_nxt   = neg_r ? mon_in_r + 4'd1 : 4'd1;
          state_nxt = S_TD_MON;
        end
      end
      S_TD_MON: begin
        if (neg_r ? (mon_r <= 4'd12) : (mon_r < mon_in_r)) begin
          k_op    = AW'(mlen_cur);
          ctl.en  = 1'b1;
          mon_nxt = mon_r + 4'd1;
        end else begin
          state_nxt = S_TD_DAY;
        end
      end
      S_TD_DAY: begin
        ctl.en = 1'b1;
        if (neg_r) begin
          // t = -(t + len - day)
          k_op        = AW'(mlen_in) - AW'(day_in_r);
          ctl.inv_acc = 1'b1;
          ctl.inv_k   = 1'b1;
        end else begin
          k_op = AW'(day_in_r);
        end
        state_nxt = S_TD_OFF;
      end
      S_TD_OFF: begin
        s_nxt     = acc[22:0];
        k_op      = {{(AW-24){off_r[23]}}, off_r};
        ctl.en    = 1'b1;
        state_nxt = S_FD_ABS;
      end
      S_FD_ABS: begin
        e_nxt    = acc[24:0];
        epos_nxt = acc_pos;
        if (!acc_pos) begin
          k_op        = AW'(1);
          ctl.inv_acc = 1'b1;
          ctl.en      = 1'b1;
        end
        ymag_nxt  = YW'(1);
        j_nxt     = 9'd1;
        state_nxt = S_FD_CYC;
      end
      S_FD_CYC: begin
        k_op      = AW'(dobd_pkg::CYC_DAYS);
        ctl.inv_k = 1'b1;
        if (sum_pos) begin
          ctl.en   = 1'b1;
          ymag_nxt = ymag_r + YW'(dobd_pkg::CYC_YEARS);
        end else begin
          state_nxt = S_FD_YR;
        end
      end
      S_FD_YR: begin
        k_op      = AW'(dobd_pkg::YEAR_DAYS) + AW'(lp_e);
        ctl.inv_k = 1'b1;
        if (sum_pos) begin
          ctl.en   = 1'b1;
          ymag_nxt = ymag_r + YW'(1);
          j_nxt    = j_r + 9'd1;
        end else begin
          mon_nxt   = epos_r ? 4'd1 : 4'd12;
          state_nxt = S_FD_MON;
        end
      end
      S_FD_MON: begin
        k_op      = AW'(mlen_e);
        ctl.inv_k = 1'b1;
        if (sum_pos && (mon_r >= 4'd1) && (mon_r <= 4'd12)) begin
          ctl.en  = 1'b1;
          mon_nxt = epos_r ? mon_r + 4'd1 : mon_r - 4'd1;
        end else begin
          if (mon_r == 4'd0) begin
            mon_nxt = 4'd1;
          end else if (mon_r > 4'd12) begin
            mon_nxt = 4'd12;
          end
          state_nxt = S_FD_DAY;
        end
      end
      S_FD_DAY: begin
        // BC: day = len - d + 1
        k_op          = AW'(mlen_e) + AW'(1);
        ctl.inv_acc   = 1'b1;
        out_valid_nxt = 1'b1;
        out_start_nxt = s_r;
        out_end_nxt   = e_r;
        if ({{(32-YW){1'b0}}, ymag_r} > MaxYear32) begin
          out_err_nxt  = 1'b1;
          out_year_nxt = '0;
          out_mon_nxt  = '0;
          out_day_nxt  = '0;
        end else begin
          out_err_nxt  = 1'b0;
          out_year_nxt = epos_r ? ymag_r[14:0] : (15'd0 - ymag_r[14:0]);
          out_mon_nxt  = mon_r;
          out_day_nxt  = epos_r ? acc[4:0] : sum[4:0];
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r       <= neg_nxt;
    rem_r       <= rem_nxt;
    k_r         <= k_nxt;
    mon_r       <= mon_nxt;
    mon_in_r    <= mon_in_nxt;
    day_in_r    <= day_in_nxt;
    off_r       <= off_nxt;
    s_r         <= s_nxt;
    e_r         <= e_nxt;
    epos_r      <= epos_nxt;
    ymag_r      <= ymag_nxt;
    j_r         <= j_nxt;
    out_start_r <= out_start_nxt;
    out_end_r   <= out_end_nxt;
    out_year_r  <= out_year_nxt;
    out_mon_r   <= out_mon_nxt;
    out_day_r   <= out_day_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_start_day_number = signed'(out_start_r);
  assign out_end_day_number   = signed'(out_end_r);
  assign out_end_year         = signed'(out_year_r);
  assign out_end_month        = out_mon_r;
  assign out_end_day          = out_day_r;
  assign out_range_error      = out_err_r;

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  a_bad_year: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_date_year == 15'sd0) |=> (out_valid && out_range_error))
    else $error("year zero not flagged");

  a_month_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_range_error) |->
      (out_end_month >= 4'd1 && out_end_month <= 4'd12 && out_end_day != 5'd0))
    else $error("result month or day out of range");

  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy without start");

endmodule
